[rtl/fsf_pkg.sv]
// Package for the flow sequence filter: packet kinds and the default table size.
package fsf_pkg;

    // Packet kinds carried on pkt_type
    localparam logic [1:0] KIND_DATA = 2'd0;
    localparam logic [1:0] KIND_ACK  = 2'd1;

    // Default number of flow entries in the table
    localparam int FLOW_ENTRIES_DEF = 16;

endpackage

[rtl/flow_seq_old_packet_filter.sv]
// Steps: accept, walk n entries (n = 0..FLOW_ENTRIES), update, then offer the result until
// out_stall is low; other packet kinds skip the walk and the update and go straight to the result.
// One packet at a time: in_stall stays high until the result is delivered, and the walk reads
// one entry per cycle through one read port.
// Reset: rst_n clears the sequencer, the fill count and the result registers at once;
// table contents are not cleared, entries below the fill count are the only ones compared.
module flow_seq_old_packet_filter
    import fsf_pkg::*;
#(
    parameter int FLOW_ENTRIES = FLOW_ENTRIES_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  pkt_type,
    input  logic [31:0] src_addr,
    input  logic [31:0] dst_addr,
    input  logic [31:0] seq_num,
    input  logic [31:0] ttl,
    input  logic [31:0] now,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        may_be_new,
    output logic        table_full
);

    localparam int IW = (FLOW_ENTRIES > 1) ? $clog2(FLOW_ENTRIES) : 1;
    localparam int CW = $clog2(FLOW_ENTRIES + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_UPDATE,
        S_OUT
    } state_t;

    // Flow table storage
    logic [31:0] src_mem [FLOW_ENTRIES];
    logic [31:0] dst_mem [FLOW_ENTRIES];
    logic [31:0] seq_mem [FLOW_ENTRIES];
    logic [31:0] tmo_mem [FLOW_ENTRIES];

    logic [31:0] src_rd_reg;
    logic [31:0] dst_rd_reg;
    logic [31:0] seq_rd_reg;
    logic [31:0] tmo_rd_reg;

    // Control and transaction registers
    state_t       state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [IW-1:0] idx_reg, idx_next;
    logic          hit_reg, hit_next;
    logic          ack_reg, ack_next;
    logic [31:0]   key_src_reg, key_src_next;
    logic [31:0]   key_dst_reg, key_dst_next;
    logic [31:0]   seq_reg, seq_next;
    logic [31:0]   now_reg, now_next;
    logic [31:0]   expire_reg, expire_next;
    logic [31:0]   base_reg, base_next;
    logic          new_reg, new_next;
    logic          full_reg, full_next;

    // Datapath and write port signals
    logic          accept;
    logic [IW-1:0] rd_addr;
    logic [IW-1:0] last_idx;
    logic [IW-1:0] wr_idx;
    logic          expired;
    logic          match;
    logic          is_new;
    logic          miss_full;
    logic          append;
    logic          ack_update;
    logic          key_we;
    logic          tmo_we;
    logic          seq_we;
    logic [IW-1:0] seq_wr_idx;
    logic [31:0]   seq_wdata;

    assign accept   = in_valid && (state_reg == S_IDLE);
    assign in_stall = (state_reg != S_IDLE);
    assign out_valid  = (state_reg == S_OUT);
    assign may_be_new = new_reg;
    assign table_full = full_reg;

    // Compare step shared by every visited entry
    assign last_idx = IW'(count_reg - CW'(1));
    assign rd_addr  = (state_reg == S_WALK) ? IW'(idx_reg + IW'(1)) : '0;
    assign expired  = now_reg > tmo_rd_reg;
    assign match    = (src_rd_reg == key_src_reg) && (dst_rd_reg == key_dst_reg);

    // Update step: judge the packet and place the table write
    assign is_new     = seq_reg > base_reg;
    assign miss_full  = !hit_reg && (count_reg == CW'(FLOW_ENTRIES));
    assign append     = !hit_reg && !miss_full;
    assign ack_update = hit_reg && ack_reg && is_new;
    assign wr_idx     = hit_reg ? idx_reg : count_reg[IW-1:0];

    assign key_we = (state_reg == S_UPDATE) && append;
    assign tmo_we = (state_reg == S_UPDATE) && (append || ack_update);

    // One seq write port: clear expired entries on the walk, store on update
    always_comb
    begin
        seq_we     = 1'b0;
        seq_wr_idx = wr_idx;
        seq_wdata  = (ack_reg && is_new) ? seq_reg : base_reg;
        if (state_reg == S_WALK)
        begin
            seq_we     = expired;
            seq_wr_idx = idx_reg;
            seq_wdata  = '0;
        end
        else if (state_reg == S_UPDATE)
        begin
            seq_we = append || ack_update;
        end
    end

    // Table read and write
    always_ff @(posedge clk)
    begin
        src_rd_reg <= src_mem[rd_addr];
        dst_rd_reg <= dst_mem[rd_addr];
        seq_rd_reg <= seq_mem[rd_addr];
        tmo_rd_reg <= tmo_mem[rd_addr];
        if (key_we)
        begin
            src_mem[wr_idx] <= key_src_reg;
            dst_mem[wr_idx] <= key_dst_reg;
        end
        if (tmo_we)
        begin
            tmo_mem[wr_idx] <= expire_reg;
        end
        if (seq_we)
        begin
            seq_mem[seq_wr_idx] <= seq_wdata;
        end
    end

    // Sequencer next state
    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        idx_next     = idx_reg;
        hit_next     = hit_reg;
        ack_next     = ack_reg;
        key_src_next = key_src_reg;
        key_dst_next = key_dst_reg;
        seq_next     = seq_reg;
        now_next     = now_reg;
        expire_next  = expire_reg;
        base_next    = base_reg;
        new_next     = new_reg;
        full_next    = full_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    ack_next     = (pkt_type == KIND_ACK);
                    key_src_next = (pkt_type == KIND_ACK) ? dst_addr : src_addr;
                    key_dst_next = (pkt_type == KIND_ACK) ? src_addr : dst_addr;
                    seq_next     = seq_num;
                    now_next     = now;
                    expire_next  = now + ttl;
                    base_next    = (pkt_type == KIND_ACK) ? (seq_num - 32'd1) : '0;
                    hit_next     = 1'b0;
                    idx_next     = '0;
                    if ((pkt_type != KIND_DATA) && (pkt_type != KIND_ACK))
                    begin
                        new_next   = 1'b0;
                        full_next  = 1'b0;
                        state_next = S_OUT;
                    end
                    else if (count_reg == '0)
                    begin
                        state_next = S_UPDATE;
                    end
                    else
                    begin
                        state_next = S_WALK;
                    end
                end
            end
            S_WALK:
            begin
                // Stop at the first matching pair, else advance or give up
                if (match)
                begin
                    hit_next   = 1'b1;
                    base_next  = expired ? '0 : seq_rd_reg;
                    state_next = S_UPDATE;
                end
                else if (idx_reg == last_idx)
                begin
                    state_next = S_UPDATE;
                end
                else
                begin
                    idx_next = IW'(idx_reg + IW'(1));
                end
            end
            S_UPDATE:
            begin
                new_next  = miss_full || is_new;
                full_next = miss_full;
                if (append)
                begin
                    count_next = CW'(count_reg + CW'(1));
                end
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!out_stall)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            new_reg   <= 1'b0;
            full_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            new_reg   <= new_next;
            full_reg  <= full_next;
        end
    end

    // Hold the transaction being worked on
    always_ff @(posedge clk)
    begin
        idx_reg     <= idx_next;
        hit_reg     <= hit_next;
        ack_reg     <= ack_next;
        key_src_reg <= key_src_next;
        key_dst_reg <= key_dst_next;
        seq_reg     <= seq_next;
        now_reg     <= now_next;
        expire_reg  <= expire_next;
        base_reg    <= base_next;
    end

`ifndef ASSERT_OFF
    // Fill count never passes the table size
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(FLOW_ENTRIES))
        else $error("flow table fill count overflow");

    // A full-table result always reports the packet as possibly new
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && table_full |-> may_be_new)
        else $error("table_full without may_be_new");

    // Fill count changes only on leaving the update step
    assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |-> ($past(state_reg) == S_UPDATE))
        else $error("fill count changed outside update");

    // A delivered result transaction frees the input side next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall |=> !in_stall && !out_valid)
        else $error("sequencer did not return to idle");
`endif

endmodule

[sim/tb_flow_seq_old_packet_filter.sv]
// Testbench for the flow sequence filter: directed and random packets checked against a table model.
`timescale 1ns / 1ps

module tb_flow_seq_old_packet_filter;
    import fsf_pkg::*;

    localparam int TABLE_DEPTH = FLOW_ENTRIES_DEF;
    localparam int POOL_KEYS = 12;
    localparam int RANDOM_ITEMS = 1400;
    localparam int FULL_ITEMS = 150;
    localparam int TAIL_CYCLES = 3 * (TABLE_DEPTH + 3);
    localparam int CYCLE_LIMIT = 1_000_000;

    // Packet kinds that the filter ignores
    localparam logic [1:0] KIND_OTHER = 2'd2;
    localparam logic [1:0] KIND_SPARE = 2'd3;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] src;
        logic [31:0] dst;
        logic [31:0] seq;
        logic [31:0] life;
        logic [31:0] at;
    } packet_t;

    typedef struct packed {
        logic fresh;
        logic full;
    } verdict_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  pkt_type;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [31:0] seq_num;
    logic [31:0] ttl;
    logic [31:0] now;
    logic        out_valid;
    logic        out_stall;
    logic        may_be_new;
    logic        table_full;

    // Flow table as the filter should hold it
    logic        flow_used [TABLE_DEPTH];
    logic [31:0] flow_src [TABLE_DEPTH];
    logic [31:0] flow_dst [TABLE_DEPTH];
    logic [31:0] flow_hi_seq [TABLE_DEPTH];
    logic [31:0] flow_expiry [TABLE_DEPTH];
    int          flow_fill;

    verdict_t    verdict_q[$];
    verdict_t    want;
    int          err_count;
    int          cycle_count;

    // Random traffic state: known flows, their sequence cursors and the wall clock
    logic [31:0] pool_a [POOL_KEYS];
    logic [31:0] pool_b [POOL_KEYS];
    logic [31:0] pool_seq [POOL_KEYS];
    logic [31:0] clock_s;
    int          steady_left;
    bit          steady_run;

    flow_seq_old_packet_filter #(
        .FLOW_ENTRIES(TABLE_DEPTH)
    ) DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .pkt_type   (pkt_type),
        .src_addr   (src_addr),
        .dst_addr   (dst_addr),
        .seq_num    (seq_num),
        .ttl        (ttl),
        .now        (now),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .may_be_new (may_be_new),
        .table_full (table_full)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Bound the run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Walk the table, clear expired numbers, append on a miss and judge the packet
    function automatic verdict_t judge_packet(packet_t p);
        verdict_t    v;
        logic [31:0] key_src;
        logic [31:0] key_dst;
        int          slot;
        bit          hit;
        v = '0;
        hit = 1'b0;
        slot = 0;
        if (p.kind != KIND_DATA && p.kind != KIND_ACK)
            return v;
        key_src = (p.kind == KIND_ACK) ? p.dst : p.src;
        key_dst = (p.kind == KIND_ACK) ? p.src : p.dst;
        for (int i = 0; i < flow_fill && !hit; i++)
        begin
            if (p.at > flow_expiry[i])
                flow_hi_seq[i] = '0;
            if (flow_used[i] && flow_src[i] == key_src && flow_dst[i] == key_dst)
            begin
                hit = 1'b1;
                slot = i;
            end
        end
        if (!hit)
        begin
            if (flow_fill >= TABLE_DEPTH)
            begin
                v.fresh = 1'b1;
                v.full = 1'b1;
                return v;
            end
            slot = flow_fill;
            flow_used[slot] = 1'b1;
            flow_src[slot] = key_src;
            flow_dst[slot] = key_dst;
            flow_hi_seq[slot] = (p.kind == KIND_ACK) ? p.seq - 32'd1 : 32'd0;
            flow_expiry[slot] = p.at + p.life;
            flow_fill++;
        end
        if (p.seq > flow_hi_seq[slot])
        begin
            v.fresh = 1'b1;
            if (p.kind == KIND_ACK)
            begin
                flow_hi_seq[slot] = p.seq;
                flow_expiry[slot] = p.at + p.life;
            end
        end
        return v;
    endfunction

    // Idle length before the next transaction: mostly short, a few long, some runs with none
    function automatic int pick_gap();
        if (steady_left == 0)
        begin
            steady_left = $urandom_range(20, 80);
            steady_run = ($urandom_range(0, 4) == 0);
        end
        steady_left--;
        if (steady_run)
            return 0;
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(8, 30);
        return $urandom_range(0, 2);
    endfunction

    // Drive one packet, hold it until accepted, then record its expected verdict
    task automatic send_pkt(input logic [1:0] kind, input logic [31:0] src,
                            input logic [31:0] dst, input logic [31:0] seq,
                            input logic [31:0] life, input logic [31:0] at);
        packet_t p;
        int      gap;
        p = '{kind: kind, src: src, dst: dst, seq: seq, life: life, at: at};
        gap = pick_gap();
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid <= 1'b1;
        pkt_type <= p.kind;
        src_addr <= p.src;
        dst_addr <= p.dst;
        seq_num <= p.seq;
        ttl <= p.life;
        now <= p.at;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        verdict_q.push_back(judge_packet(p));
    endtask

    // Hold off the sender until every verdict has come back
    task automatic drain_verdicts();
        @(negedge clk);
        in_valid <= 1'b0;
        while (verdict_q.size() != 0)
            @(posedge clk);
    endtask

    // Send one data or ack packet on a known flow, near its sequence cursor
    task automatic send_pool_item();
        int          k;
        logic [1:0]  kind;
        logic [31:0] seq;
        logic [31:0] life;
        k = $urandom_range(0, POOL_KEYS - 1);
        kind = ($urandom_range(0, 9) < 5) ? KIND_DATA : KIND_ACK;
        case ($urandom_range(0, 19))
            0: seq = $urandom;
            1: seq = pool_seq[k] - $urandom_range(1, 50);
            default: seq = pool_seq[k] + $urandom_range(0, 4) - 32'd1;
        endcase
        if (seq > pool_seq[k] || $urandom_range(0, 19) == 0)
            pool_seq[k] = seq;
        case ($urandom_range(0, 19))
            0: life = '0;
            1: life = $urandom;
            default: life = $urandom_range(2, 40);
        endcase
        clock_s = clock_s + $urandom_range(0, 3);
        if ($urandom_range(0, 99) == 0)
            clock_s = $urandom;
        if (kind == KIND_ACK)
            send_pkt(kind, pool_b[k], pool_a[k], seq, life, clock_s);
        else
            send_pkt(kind, pool_a[k], pool_b[k], seq, life, clock_s);
    endtask

    // Other kinds leave the table alone and are always old
    task automatic test_other_kinds();
        send_pkt(KIND_OTHER, '1, '1, '1, '1, '1);
        send_pkt(KIND_SPARE, '0, '0, '0, '0, '0);
    endtask

    // Data against stored numbers, acks raising them, ack misses with seq 0
    task automatic test_data_and_ack();
        send_pkt(KIND_DATA, 32'h0000_0000, 32'hFFFF_FFFF, 32'd5, 32'd100, 32'd1000);
        send_pkt(KIND_DATA, 32'h0000_0000, 32'hFFFF_FFFF, 32'd0, 32'd100, 32'd1001);
        send_pkt(KIND_DATA, 32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd100, 32'd1002);
        send_pkt(KIND_ACK, 32'hFFFF_FFFF, 32'h0000_0000, 32'd10, 32'd100, 32'd1010);
        send_pkt(KIND_DATA, 32'h0000_0000, 32'hFFFF_FFFF, 32'd10, 32'd100, 32'd1020);
        send_pkt(KIND_DATA, 32'h0000_0000, 32'hFFFF_FFFF, 32'd11, 32'd100, 32'd1020);
        send_pkt(KIND_ACK, 32'hFFFF_FFFF, 32'h0000_0000, 32'd3, 32'd100, 32'd1021);
        send_pkt(KIND_ACK, 32'h1234_5678, 32'h9ABC_DEF0, 32'd0, 32'd200, 32'd1022);
        send_pkt(KIND_ACK, 32'h1234_5678, 32'h9ABC_DEF0, 32'hFFFF_FFFF, 32'd200, 32'd1023);
        send_pkt(KIND_DATA, 32'h9ABC_DEF0, 32'h1234_5678, 32'd1, 32'd200, 32'd1030);
    endtask

    // Expiry clears visited numbers; timeouts wrap around the top of the clock
    task automatic test_expiry_and_wrap();
        send_pkt(KIND_DATA, 32'h9ABC_DEF0, 32'h1234_5678, 32'd1, 32'd50, 32'd5000);
        send_pkt(KIND_DATA, 32'h0000_0000, 32'hFFFF_FFFF, 32'd1, 32'd50, 32'd5000);
        send_pkt(KIND_ACK, 32'hAAAA_5555, 32'h5555_AAAA, 32'd100, 32'h20, 32'hFFFF_FFF0);
        send_pkt(KIND_ACK, 32'hAAAA_5555, 32'h5555_AAAA, 32'd100, 32'h20, 32'h0000_0005);
        send_pkt(KIND_ACK, 32'hAAAA_5555, 32'h5555_AAAA, 32'd100, 32'h20, 32'h0000_0011);
        send_pkt(KIND_ACK, 32'hFFFF_FFFF, 32'h0000_0000, 32'd7, 32'hFFFF_FFFF, 32'd0);
        send_pkt(KIND_DATA, 32'h0000_0000, 32'hFFFF_FFFF, 32'd7, 32'd0, 32'hFFFF_FFFF);
        send_pkt(KIND_SPARE, '1, '1, '1, '1, '1);
    endtask

    // Mostly well-formed flow traffic with some ignored kinds mixed in
    task automatic test_random_traffic();
        int sent;
        for (int k = 0; k < POOL_KEYS; k++)
        begin
            pool_a[k] = $urandom;
            pool_b[k] = $urandom;
            pool_seq[k] = $urandom_range(0, 1000);
        end
        clock_s = $urandom_range(0, 100000);
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 11) == 0)
            begin
                send_pkt($urandom_range(0, 1) ? KIND_OTHER : KIND_SPARE,
                         $urandom, $urandom, $urandom, $urandom, $urandom);
            end
            else
            begin
                send_pool_item();
                sent++;
            end
            if ($urandom_range(0, 199) == 0)
                drain_verdicts();
        end
    endtask

    // Fill the table, then mix misses that find no room with hits on known flows
    task automatic test_table_full();
        while (flow_fill < TABLE_DEPTH)
            send_pkt(KIND_DATA, $urandom, $urandom, $urandom, $urandom_range(1, 40), clock_s);
        send_pkt(KIND_ACK, $urandom, $urandom, 32'd0, 32'd10, clock_s);
        for (int n = 0; n < FULL_ITEMS; n++)
        begin
            if ($urandom_range(0, 2) == 0)
            begin
                clock_s = clock_s + $urandom_range(0, 3);
                send_pkt($urandom_range(0, 1) ? KIND_DATA : KIND_ACK, $urandom, $urandom,
                         $urandom, $urandom_range(1, 40), clock_s);
            end
            else
            begin
                send_pool_item();
            end
        end
    endtask

    // Check each result transaction against the oldest expected verdict
    always @(posedge clk)
    begin
        if (rst_n && out_valid === 1'b1 && out_stall == 1'b0)
        begin
            if (verdict_q.size() == 0)
            begin
                $error("result with no packet pending: may_be_new %0b table_full %0b",
                       may_be_new, table_full);
                err_count++;
            end
            else
            begin
                want = verdict_q.pop_front();
                if (may_be_new !== want.fresh)
                begin
                    $error("may_be_new: expected %0b, got %0b", want.fresh, may_be_new);
                    err_count++;
                end
                if (table_full !== want.full)
                begin
                    $error("table_full: expected %0b, got %0b", want.full, table_full);
                    err_count++;
                end
            end
        end
    end

    // Stall the result side in short and long bursts, with quiet stretches between
    initial
    begin
        int n;
        out_stall = 1'b0;
        forever
        begin
            if ($urandom_range(0, 7) == 0)
            begin
                repeat ($urandom_range(50, 200)) @(negedge clk) out_stall <= 1'b0;
            end
            else
            begin
                repeat ($urandom_range(0, 6)) @(negedge clk) out_stall <= 1'b0;
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
                repeat (n) @(negedge clk) out_stall <= 1'b1;
            end
        end
    end

    // Reset, run each test with a full drain between them, then report
    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        pkt_type = '0;
        src_addr = '0;
        dst_addr = '0;
        seq_num = '0;
        ttl = '0;
        now = '0;
        flow_fill = 0;
        err_count = 0;
        cycle_count = 0;
        steady_left = 0;
        steady_run = 1'b0;
        clock_s = '0;
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            flow_used[i] = 1'b0;
            flow_src[i] = '0;
            flow_dst[i] = '0;
            flow_hi_seq[i] = '0;
            flow_expiry[i] = '0;
        end
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;

        test_other_kinds();
        drain_verdicts();
        test_data_and_ack();
        drain_verdicts();
        test_expiry_and_wrap();
        drain_verdicts();
        test_random_traffic();
        drain_verdicts();
        test_table_full();
        drain_verdicts();

        repeat (TAIL_CYCLES) @(posedge clk);
        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
